/* src/ipv4_five_tuple_classifier_unit_macros.svh */
// assertion macros shared by the classifier modules
`ifndef IPV4_FIVE_TUPLE_CLASSIFIER_UNIT_MACROS_SVH
`define IPV4_FIVE_TUPLE_CLASSIFIER_UNIT_MACROS_SVH

// property checked at every clock edge outside reset
`define IFTC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define IFTC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/iftc_pkg.sv */
`timescale 1ns / 1ps

package iftc_pkg;

   // statistics counter width
   localparam int CntWidth = 64;
   typedef logic [CntWidth-1:0] cnt_type;

   // protocol constants
   localparam logic [15:0] EthertypeIpv4 = 16'h0800;
   localparam logic [7:0]  ProtoTcp      = 8'd6;
   localparam logic [7:0]  ProtoUdp      = 8'd17;

   // byte offsets within the frame
   localparam logic [5:0] PosTypeHi   = 6'd12;
   localparam logic [5:0] PosTypeLo   = 6'd13;
   localparam logic [5:0] PosProto    = 6'd23;
   localparam logic [5:0] PosSrcFirst = 6'd26;
   localparam logic [5:0] PosSrcLast  = 6'd29;
   localparam logic [5:0] PosDstFirst = 6'd30;
   localparam logic [5:0] PosDstLast  = 6'd33;
   localparam logic [5:0] PosSportHi  = 6'd34;
   localparam logic [5:0] PosSportLo  = 6'd35;
   localparam logic [5:0] PosDportHi  = 6'd36;
   localparam logic [5:0] PosDportLo  = 6'd37;
   localparam logic [5:0] PosMax      = 6'd63;

   // minimum frame lengths
   localparam logic [6:0] MinEthLen  = 7'd14;
   localparam logic [6:0] MinIpv4Len = 7'd34;
   localparam logic [6:0] MinUdpLen  = 7'd42;
   localparam logic [6:0] MinTcpLen  = 7'd54;

   // class action codes
   localparam logic [1:0] ActNone = 2'd0;
   localparam logic [1:0] ActDrop = 2'd1;
   localparam logic [1:0] ActMark = 2'd2;
   localparam logic [1:0] ActPass = 2'd3;

   // configuration register indexes
   localparam int CsrIdxWidth  = 4;
   localparam int CsrDataWidth = 32;
   localparam logic [CsrIdxWidth-1:0] RegSrcAddr  = 4'd0;
   localparam logic [CsrIdxWidth-1:0] RegSrcMask  = 4'd1;
   localparam logic [CsrIdxWidth-1:0] RegDstAddr  = 4'd2;
   localparam logic [CsrIdxWidth-1:0] RegDstMask  = 4'd3;
   localparam logic [CsrIdxWidth-1:0] RegPorts    = 4'd4;
   localparam logic [CsrIdxWidth-1:0] RegProtocol = 4'd5;
   localparam logic [CsrIdxWidth-1:0] RegAction   = 4'd6;
   localparam logic [CsrIdxWidth-1:0] RegMarkIdx  = 4'd7;

   // finished frame handed from parser to classifier
   typedef struct packed {
      logic [15:0] ether_type;
      logic [7:0]  protocol;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [5:0]  last_pos;
      cnt_type     bytes_total;
   } frame_rec_type;

endpackage

/* src/iftc_if.sv */
`timescale 1ns / 1ps

// frame byte channel
interface iftc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// verdict channel
interface iftc_rsp_if;
   logic                 valid;
   logic                 ready;
   logic                 verdict;
   logic                 set_index;
   logic [15:0]          index_value;
   iftc_pkg::cnt_type    packets_total;
   iftc_pkg::cnt_type    bytes_total;
   iftc_pkg::cnt_type    packets_passed;
   iftc_pkg::cnt_type    packets_dropped;
   iftc_pkg::cnt_type    packets_marked;

   modport source (output valid, output verdict, output set_index, output index_value,
                   output packets_total, output bytes_total, output packets_passed,
                   output packets_dropped, output packets_marked, input ready);
   modport sink (input valid, input verdict, input set_index, input index_value,
                 input packets_total, input bytes_total, input packets_passed,
                 input packets_dropped, input packets_marked, output ready);
endinterface

/* src/iftc_parser.sv */
`timescale 1ns / 1ps
`include "ipv4_five_tuple_classifier_unit_macros.svh"

module iftc_parser (
   input  logic                   clock,
   input  logic                   reset,
   iftc_req_if.sink               req_bus,
   output logic                   rec_valid,
   input  logic                   rec_ready,
   output iftc_pkg::frame_rec_type rec
);

   logic [5:0]              pos_ff, pos_in;
   logic [15:0]             ether_type_ff, ether_type_in;
   logic [7:0]              protocol_ff, protocol_in;
   logic [31:0]             src_addr_ff, src_addr_in;
   logic [31:0]             dst_addr_ff, dst_addr_in;
   logic [15:0]             sport_ff, sport_in;
   logic [15:0]             dport_ff, dport_in;
   iftc_pkg::cnt_type       bytes_ff, bytes_in;
   logic                    rec_valid_ff, rec_valid_in;
   iftc_pkg::frame_rec_type rec_ff, rec_in;
   logic                    accept;
   logic [7:0]              b;

   assign req_bus.ready = !rec_valid_ff || rec_ready;
   assign accept        = req_bus.valid && req_bus.ready;
   assign b             = req_bus.data_byte;

   // field capture for the byte at the current position
   always_comb begin
      ether_type_in = ether_type_ff;
      protocol_in   = protocol_ff;
      src_addr_in   = src_addr_ff;
      dst_addr_in   = dst_addr_ff;
      sport_in      = sport_ff;
      dport_in      = dport_ff;
      if (pos_ff == iftc_pkg::PosTypeHi) begin
         ether_type_in = {b, 8'h00};
      end else if (pos_ff == iftc_pkg::PosTypeLo) begin
         ether_type_in = ether_type_ff | {8'h00, b};
      end else if (pos_ff == iftc_pkg::PosProto) begin
         protocol_in = b;
      end else if (pos_ff inside {[iftc_pkg::PosSrcFirst:iftc_pkg::PosSrcLast]}) begin
         src_addr_in = {src_addr_ff[23:0], b};
      end else if (pos_ff inside {[iftc_pkg::PosDstFirst:iftc_pkg::PosDstLast]}) begin
         dst_addr_in = {dst_addr_ff[23:0], b};
      end else if (pos_ff inside {iftc_pkg::PosSportHi, iftc_pkg::PosSportLo}) begin
         sport_in = {sport_ff[7:0], b};
      end else if (pos_ff inside {iftc_pkg::PosDportHi, iftc_pkg::PosDportLo}) begin
         dport_in = {dport_ff[7:0], b};
      end
      pos_in   = (pos_ff == iftc_pkg::PosMax) ? pos_ff : pos_ff + 6'd1;
      bytes_in = bytes_ff + iftc_pkg::cnt_type'(1);
   end

   // frame record built from the capture including the last byte
   always_comb begin
      rec_in.ether_type  = ether_type_in;
      rec_in.protocol    = protocol_in;
      rec_in.src_addr    = src_addr_in;
      rec_in.dst_addr    = dst_addr_in;
      rec_in.sport       = sport_in;
      rec_in.dport       = dport_in;
      rec_in.last_pos    = pos_ff;
      rec_in.bytes_total = bytes_in;
      rec_valid_in       = rec_valid_ff;
      if (rec_ready) begin
         rec_valid_in = 1'b0;
      end
      if (accept && req_bus.last_byte) begin
         rec_valid_in = 1'b1;
      end
   end

   // capture state, cleared after each last byte; the byte count keeps running
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         ether_type_ff <= '0;
         protocol_ff   <= '0;
         src_addr_ff   <= '0;
         dst_addr_ff   <= '0;
         sport_ff      <= '0;
         dport_ff      <= '0;
         bytes_ff      <= '0;
         rec_valid_ff  <= 1'b0;
      end else begin
         rec_valid_ff <= rec_valid_in;
         if (accept) begin
            bytes_ff <= bytes_in;
            if (req_bus.last_byte) begin
               pos_ff        <= '0;
               ether_type_ff <= '0;
               protocol_ff   <= '0;
               src_addr_ff   <= '0;
               dst_addr_ff   <= '0;
               sport_ff      <= '0;
               dport_ff      <= '0;
            end else begin
               pos_ff        <= pos_in;
               ether_type_ff <= ether_type_in;
               protocol_ff   <= protocol_in;
               src_addr_ff   <= src_addr_in;
               dst_addr_ff   <= dst_addr_in;
               sport_ff      <= sport_in;
               dport_ff      <= dport_in;
            end
         end
      end
   end

   // record payload
   always_ff @(posedge clock) begin
      if (accept && req_bus.last_byte) begin
         rec_ff <= rec_in;
      end
   end

   assign rec_valid = rec_valid_ff;
   assign rec       = rec_ff;

   // checks
   `IFTC_ASSERT_NEXT(a_rec_hold, rec_valid_ff && !rec_ready,
                     rec_valid_ff && $stable(rec_ff), "frame record lost while stalled")
   `IFTC_ASSERT_NEXT(a_pos_clear, accept && req_bus.last_byte,
                     pos_ff == 6'd0 && src_addr_ff == 32'd0, "capture not cleared after frame")
   `IFTC_ASSERT_NEXT(a_pos_sat, accept && !req_bus.last_byte && pos_ff == iftc_pkg::PosMax,
                     pos_ff == iftc_pkg::PosMax, "byte position wrapped")
   `IFTC_ASSERT_NEXT(a_bytes_count, accept,
                     bytes_ff == $past(bytes_ff) + iftc_pkg::cnt_type'(1),
                     "byte counter missed a byte")

endmodule

/* src/iftc_classifier.sv */
`timescale 1ns / 1ps
`include "ipv4_five_tuple_classifier_unit_macros.svh"

module iftc_classifier (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [iftc_pkg::CsrIdxWidth-1:0]   csr_index,
   input  logic [iftc_pkg::CsrDataWidth-1:0]  csr_write_data,
   input  logic                               rec_valid,
   output logic                               rec_ready,
   input  iftc_pkg::frame_rec_type            rec,
   iftc_rsp_if.source                         rsp_bus
);

   logic [31:0]       src_addr_ff, src_mask_ff, dst_addr_ff, dst_mask_ff, ports_ff;
   logic [7:0]        proto_ff;
   logic [1:0]        action_ff;
   logic [15:0]       mark_idx_ff;

   logic              out_valid_ff;
   logic              verdict_ff, verdict_in;
   logic              set_index_ff, set_index_in;
   logic [15:0]       index_ff, index_in;
   iftc_pkg::cnt_type bytes_ff;
   iftc_pkg::cnt_type total_ff, passed_ff, dropped_ff, marked_ff;
   logic              inc_pass, inc_drop, inc_mark;
   logic              take;
   logic [6:0]        frame_len;
   logic              fits;
   logic [15:0]       sp, dp;
   logic              hit;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         src_addr_ff <= '0;
         src_mask_ff <= '0;
         dst_addr_ff <= '0;
         dst_mask_ff <= '0;
         ports_ff    <= '0;
         proto_ff    <= '0;
         action_ff   <= iftc_pkg::ActNone;
         mark_idx_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            iftc_pkg::RegSrcAddr:  src_addr_ff <= csr_write_data;
            iftc_pkg::RegSrcMask:  src_mask_ff <= csr_write_data;
            iftc_pkg::RegDstAddr:  dst_addr_ff <= csr_write_data;
            iftc_pkg::RegDstMask:  dst_mask_ff <= csr_write_data;
            iftc_pkg::RegPorts:    ports_ff    <= csr_write_data;
            iftc_pkg::RegProtocol: proto_ff    <= csr_write_data[7:0];
            iftc_pkg::RegAction:   action_ff   <= csr_write_data[1:0];
            iftc_pkg::RegMarkIdx:  mark_idx_ff <= csr_write_data[15:0];
            default: ;
         endcase
      end
   end

   assign rec_ready = !out_valid_ff || rsp_bus.ready;
   assign take      = rec_valid && rec_ready;

   // filter match and verdict
   always_comb begin
      frame_len = {1'b0, rec.last_pos} + 7'd1;
      fits = (rec.protocol == iftc_pkg::ProtoTcp && frame_len >= iftc_pkg::MinTcpLen) ||
             (rec.protocol == iftc_pkg::ProtoUdp && frame_len >= iftc_pkg::MinUdpLen);
      sp = fits ? rec.sport : 16'd0;
      dp = fits ? rec.dport : 16'd0;
      hit = ((rec.src_addr & src_mask_ff) == (src_addr_ff & src_mask_ff)) &&
            ((rec.dst_addr & dst_mask_ff) == (dst_addr_ff & dst_mask_ff)) &&
            (proto_ff == 8'd0 || proto_ff == rec.protocol) &&
            (ports_ff[31:16] == 16'd0 || ports_ff[31:16] == sp) &&
            (ports_ff[15:0] == 16'd0 || ports_ff[15:0] == dp);
      verdict_in   = 1'b0;
      set_index_in = 1'b0;
      index_in     = 16'd0;
      inc_pass     = 1'b0;
      inc_drop     = 1'b0;
      inc_mark     = 1'b0;
      if (frame_len < iftc_pkg::MinEthLen) begin
         // runt frame
         verdict_in = 1'b1;
      end else if (rec.ether_type != iftc_pkg::EthertypeIpv4) begin
         // not ipv4: pass uncounted
         verdict_in = 1'b0;
      end else if (frame_len < iftc_pkg::MinIpv4Len) begin
         // truncated ipv4 header
         verdict_in = 1'b1;
      end else if (hit && action_ff == iftc_pkg::ActDrop) begin
         verdict_in = 1'b1;
         inc_drop   = 1'b1;
      end else begin
         if (hit && action_ff == iftc_pkg::ActMark) begin
            set_index_in = 1'b1;
            index_in     = mark_idx_ff;
            inc_mark     = 1'b1;
         end
         inc_pass = 1'b1;
      end
   end

   // result register and statistics
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         total_ff     <= '0;
         passed_ff    <= '0;
         dropped_ff   <= '0;
         marked_ff    <= '0;
      end else begin
         if (take) begin
            out_valid_ff <= 1'b1;
            total_ff     <= total_ff + iftc_pkg::cnt_type'(1);
            passed_ff    <= passed_ff + iftc_pkg::cnt_type'(inc_pass);
            dropped_ff   <= dropped_ff + iftc_pkg::cnt_type'(inc_drop);
            marked_ff    <= marked_ff + iftc_pkg::cnt_type'(inc_mark);
         end else if (rsp_bus.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         verdict_ff   <= verdict_in;
         set_index_ff <= set_index_in;
         index_ff     <= index_in;
         bytes_ff     <= rec.bytes_total;
      end
   end

   assign rsp_bus.valid           = out_valid_ff;
   assign rsp_bus.verdict         = verdict_ff;
   assign rsp_bus.set_index       = set_index_ff;
   assign rsp_bus.index_value     = index_ff;
   assign rsp_bus.packets_total   = total_ff;
   assign rsp_bus.bytes_total     = bytes_ff;
   assign rsp_bus.packets_passed  = passed_ff;
   assign rsp_bus.packets_dropped = dropped_ff;
   assign rsp_bus.packets_marked  = marked_ff;

   // checks
   `IFTC_ASSERT(a_drop_not_marked, !(out_valid_ff && verdict_ff && set_index_ff),
                "dropped frame also marked")
   `IFTC_ASSERT(a_index_zero, !(out_valid_ff && !set_index_ff && index_ff != 16'd0),
                "index given to unmarked frame")
   `IFTC_ASSERT_NEXT(a_total_step, take,
                     total_ff == $past(total_ff) + iftc_pkg::cnt_type'(1),
                     "frame counter missed a frame")
   `IFTC_ASSERT_NEXT(a_stats_hold, !take,
                     $stable(total_ff) && $stable(passed_ff) && $stable(dropped_ff),
                     "statistics changed without a frame")

endmodule

/* src/ipv4_five_tuple_classifier_unit.sv */
`timescale 1ns / 1ps
// channel    | dir | handshake     | payload
// req_bus    | in  | valid/ready   | data_byte, last_byte
// rsp_bus    | out | valid/ready   | verdict, set_index, index_value, five counters
// csr port   | in  | write enable  | csr_index, csr_write_data
//
// one byte per cycle unless stalled; a verdict passes both stages after the last byte
// the byte parser register and the result register form the only two stages
// synchronous active-high reset clears the filter, the capture state and all counters
// a stalled result holds the record stage, which then holds the byte input

module ipv4_five_tuple_classifier_unit (
   input  logic                               clock,
   input  logic                               reset,
   iftc_req_if.sink                           req_bus,
   iftc_rsp_if.source                         rsp_bus,
   input  logic                               csr_write_enable,
   input  logic [iftc_pkg::CsrIdxWidth-1:0]   csr_index,
   input  logic [iftc_pkg::CsrDataWidth-1:0]  csr_write_data
);

   logic                    rec_valid;
   logic                    rec_ready;
   iftc_pkg::frame_rec_type rec;

   // byte capture
   iftc_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rec_valid (rec_valid),
      .rec_ready (rec_ready),
      .rec       (rec)
   );

   // filter, action and statistics
   iftc_classifier u_classifier (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rec_valid        (rec_valid),
      .rec_ready        (rec_ready),
      .rec              (rec),
      .rsp_bus          (rsp_bus)
   );

endmodule

/* bench/iftc_verdict_checker.sv */
`timescale 1ns / 1ps

module iftc_verdict_checker (
   input  logic                              clock,
   input  logic                              reset,
   iftc_req_if                               req_bus,
   iftc_rsp_if                               rsp_bus,
   input  logic                              csr_write_enable,
   input  logic [iftc_pkg::CsrIdxWidth-1:0]  csr_index,
   input  logic [iftc_pkg::CsrDataWidth-1:0] csr_write_data,
   output int                                mismatch_count,
   output int                                verdicts_awaited
);

   import iftc_pkg::*;

   typedef struct packed {
      logic        verdict;
      logic        set_index;
      logic [15:0] index_value;
      cnt_type     packets_total;
      cnt_type     bytes_total;
      cnt_type     packets_passed;
      cnt_type     packets_dropped;
      cnt_type     packets_marked;
   } frame_verdict_type;

   // verdicts still owed by the block, oldest first
   frame_verdict_type verdict_queue[$];
   int unsigned       verdicts_seen;

   // filter copy, tracked from the csr port
   logic [31:0] flt_src_addr;
   logic [31:0] flt_src_mask;
   logic [31:0] flt_dst_addr;
   logic [31:0] flt_dst_mask;
   logic [31:0] flt_ports;
   logic [7:0]  flt_protocol;
   logic [1:0]  flt_action;
   logic [15:0] flt_mark_index;

   // header capture of the frame in flight
   logic [5:0]  byte_pos;
   logic [15:0] cap_ether_type;
   logic [7:0]  cap_protocol;
   logic [31:0] cap_src_addr;
   logic [31:0] cap_dst_addr;
   logic [15:0] cap_sport;
   logic [15:0] cap_dport;

   // statistics
   cnt_type cnt_frames;
   cnt_type cnt_bytes;
   cnt_type cnt_passed;
   cnt_type cnt_dropped;
   cnt_type cnt_marked;

   initial mismatch_count = 0;

   task automatic clear_capture();
      byte_pos       = '0;
      cap_ether_type = '0;
      cap_protocol   = '0;
      cap_src_addr   = '0;
      cap_dst_addr   = '0;
      cap_sport      = '0;
      cap_dport      = '0;
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (mismatch_count < 100) begin
         $display("[%0t] verdict %0d %s: got 0x%0h, expected 0x%0h",
                  $time, verdicts_seen, what, got, want);
      end
      mismatch_count++;
   endtask

   task automatic check_field(input string what, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want) begin
         report_mismatch(what, got, want);
      end
   endtask

   // capture one frame byte; at the last byte classify and queue the verdict
   task automatic classify_byte(input logic [7:0] data, input logic is_last);
      logic [6:0]        frame_len;
      logic [15:0]       seen_sport;
      logic [15:0]       seen_dport;
      logic [15:0]       want_sport;
      logic [15:0]       want_dport;
      logic              ports_present;
      logic              hit;
      frame_verdict_type v;
      if (byte_pos == PosTypeHi) begin
         cap_ether_type = {data, 8'h00};
      end else if (byte_pos == PosTypeLo) begin
         cap_ether_type[7:0] = data;
      end else if (byte_pos == PosProto) begin
         cap_protocol = data;
      end else if (byte_pos >= PosSrcFirst && byte_pos <= PosSrcLast) begin
         cap_src_addr = {cap_src_addr[23:0], data};
      end else if (byte_pos >= PosDstFirst && byte_pos <= PosDstLast) begin
         cap_dst_addr = {cap_dst_addr[23:0], data};
      end else if (byte_pos == PosSportHi || byte_pos == PosSportLo) begin
         cap_sport = {cap_sport[7:0], data};
      end else if (byte_pos == PosDportHi || byte_pos == PosDportLo) begin
         cap_dport = {cap_dport[7:0], data};
      end
      cnt_bytes = cnt_bytes + cnt_type'(1);
      frame_len = {1'b0, byte_pos} + 7'd1;
      if (byte_pos != PosMax) begin
         byte_pos = byte_pos + 6'd1;
      end

      if (is_last) begin
         v = '0;
         cnt_frames = cnt_frames + cnt_type'(1);
         if (frame_len < MinEthLen) begin
            // runt
            v.verdict = 1'b1;
         end else if (cap_ether_type != EthertypeIpv4) begin
            // not ipv4: passes, not counted as passed
            v.verdict = 1'b0;
         end else if (frame_len < MinIpv4Len) begin
            // truncated ipv4 header
            v.verdict = 1'b1;
         end else begin
            // ports only count when the whole l4 header is present
            ports_present = (cap_protocol == ProtoTcp && frame_len >= MinTcpLen) ||
                            (cap_protocol == ProtoUdp && frame_len >= MinUdpLen);
            seen_sport = ports_present ? cap_sport : 16'h0000;
            seen_dport = ports_present ? cap_dport : 16'h0000;
            want_sport = flt_ports[31:16];
            want_dport = flt_ports[15:0];
            hit = ((cap_src_addr & flt_src_mask) == (flt_src_addr & flt_src_mask)) &&
                  ((cap_dst_addr & flt_dst_mask) == (flt_dst_addr & flt_dst_mask)) &&
                  (flt_protocol == 8'h00 || flt_protocol == cap_protocol) &&
                  (want_sport == 16'h0000 || want_sport == seen_sport) &&
                  (want_dport == 16'h0000 || want_dport == seen_dport);
            if (hit && flt_action == ActDrop) begin
               v.verdict   = 1'b1;
               cnt_dropped = cnt_dropped + cnt_type'(1);
            end else begin
               if (hit && flt_action == ActMark) begin
                  v.set_index   = 1'b1;
                  v.index_value = flt_mark_index;
                  cnt_marked    = cnt_marked + cnt_type'(1);
               end
               cnt_passed = cnt_passed + cnt_type'(1);
            end
         end
         v.packets_total   = cnt_frames;
         v.bytes_total     = cnt_bytes;
         v.packets_passed  = cnt_passed;
         v.packets_dropped = cnt_dropped;
         v.packets_marked  = cnt_marked;
         verdict_queue.push_back(v);
         clear_capture();
      end
   endtask

   always @(posedge clock) begin
      frame_verdict_type want;
      if (reset) begin
         verdict_queue.delete();
         verdicts_seen  = 0;
         flt_src_addr   = '0;
         flt_src_mask   = '0;
         flt_dst_addr   = '0;
         flt_dst_mask   = '0;
         flt_ports      = '0;
         flt_protocol   = '0;
         flt_action     = ActNone;
         flt_mark_index = '0;
         cnt_frames     = '0;
         cnt_bytes      = '0;
         cnt_passed     = '0;
         cnt_dropped    = '0;
         cnt_marked     = '0;
         clear_capture();
      end else begin
         // filter register writes, truncated to register width
         if (csr_write_enable) begin
            case (csr_index)
               RegSrcAddr:  flt_src_addr   = csr_write_data;
               RegSrcMask:  flt_src_mask   = csr_write_data;
               RegDstAddr:  flt_dst_addr   = csr_write_data;
               RegDstMask:  flt_dst_mask   = csr_write_data;
               RegPorts:    flt_ports      = csr_write_data;
               RegProtocol: flt_protocol   = csr_write_data[7:0];
               RegAction:   flt_action     = csr_write_data[1:0];
               RegMarkIdx:  flt_mark_index = csr_write_data[15:0];
               default: ;
            endcase
         end

         // compare the verdict leaving the block before queueing new ones
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (verdict_queue.size() == 0) begin
               report_mismatch("verdict with none outstanding", 64'h0, 64'h0);
            end else begin
               want = verdict_queue.pop_front();
               check_field("verdict", rsp_bus.verdict, want.verdict);
               check_field("set_index", rsp_bus.set_index, want.set_index);
               check_field("index_value", rsp_bus.index_value, want.index_value);
               check_field("packets_total", rsp_bus.packets_total, want.packets_total);
               check_field("bytes_total", rsp_bus.bytes_total, want.bytes_total);
               check_field("packets_passed", rsp_bus.packets_passed, want.packets_passed);
               check_field("packets_dropped", rsp_bus.packets_dropped, want.packets_dropped);
               check_field("packets_marked", rsp_bus.packets_marked, want.packets_marked);
            end
            verdicts_seen++;
         end

         // accepted frame byte request
         if (req_bus.valid && req_bus.ready) begin
            classify_byte(req_bus.data_byte, req_bus.last_byte);
         end
      end
      verdicts_awaited = verdict_queue.size();
   end

endmodule

/* bench/ipv4_five_tuple_classifier_unit_test.sv */
`timescale 1ns / 1ps

module ipv4_five_tuple_classifier_unit_test;

   import iftc_pkg::*;

   localparam int          CycleLimit   = 400000;
   localparam int          HoldSpacing  = 400;
   localparam int          HoldLength   = 120;
   localparam int          ByteBudget   = 1050;
   localparam int          FillRandom   = 0;
   localparam int          FillZero     = 1;
   localparam int          FillOnes     = 2;
   localparam logic [CsrIdxWidth-1:0] RegUnusedFirst = RegMarkIdx + CsrIdxWidth'(1);

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    csr_write_enable;
   logic [CsrIdxWidth-1:0]  csr_index;
   logic [CsrDataWidth-1:0] csr_write_data;
   int                      mismatch_count;
   int                      verdicts_awaited;

   iftc_req_if req_bus ();
   iftc_rsp_if rsp_bus ();

   ipv4_five_tuple_classifier_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   iftc_verdict_checker verdict_check (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatch_count),
      .verdicts_awaited (verdicts_awaited)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   int unsigned cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // verdict receiver: shifting stall pattern plus occasional long hold-off
   int unsigned rx_cycle;
   int unsigned hold_left;
   int unsigned since_hold;
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rx_cycle   = 0;
         hold_left  = 0;
         since_hold = 0;
      end else begin
         rx_cycle++;
         since_hold++;
         if (hold_left == 0 && rsp_bus.valid && since_hold > HoldSpacing) begin
            hold_left  = HoldLength;
            since_hold = 0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            case ((rx_cycle / 256) % 4)
               0:       rsp_bus.ready <= 1'b1;
               1:       rsp_bus.ready <= ($urandom_range(0, 1) == 0);
               2:       rsp_bus.ready <= ($urandom_range(0, 9) != 0);
               default: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // stimulus-side copy of the filter, used only to steer frames toward hits
   logic [31:0] f_src_addr;
   logic [31:0] f_src_mask;
   logic [31:0] f_dst_addr;
   logic [31:0] f_dst_mask;
   logic [31:0] f_ports;
   logic [7:0]  f_protocol;

   int  burst_left;
   bit  gapless;
   int  bytes_sent;

   // one byte request, with bursts and gaps on the sender side
   task automatic drive_byte(input logic [7:0] data, input logic is_last);
      int gap;
      if (burst_left == 0) begin
         gap = gapless ? 0 : $urandom_range(0, 6);
         if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 60);
      end
      req_bus.valid     <= 1'b1;
      req_bus.data_byte <= data;
      req_bus.last_byte <= is_last;
      do @(posedge clock); while (!req_bus.ready);
      burst_left--;
      bytes_sent++;
   endtask

   // build a frame with the given header fields and send it byte by byte
   task automatic send_frame(input int len, input logic [15:0] etype, input logic [7:0] proto,
                             input logic [31:0] src, input logic [31:0] dst,
                             input logic [15:0] sport, input logic [15:0] dport,
                             input int fill);
      logic [7:0] b;
      for (int i = 0; i < len; i++) begin
         case (fill)
            FillZero: b = 8'h00;
            FillOnes: b = 8'hFF;
            default:  b = 8'($urandom);
         endcase
         if (i == PosTypeHi) b = etype[15:8];
         else if (i == PosTypeLo) b = etype[7:0];
         else if (i == PosProto) b = proto;
         else if (i >= PosSrcFirst && i <= PosSrcLast) b = src[8*(PosSrcLast-i) +: 8];
         else if (i >= PosDstFirst && i <= PosDstLast) b = dst[8*(PosDstLast-i) +: 8];
         else if (i == PosSportHi) b = sport[15:8];
         else if (i == PosSportLo) b = sport[7:0];
         else if (i == PosDportHi) b = dport[15:8];
         else if (i == PosDportLo) b = dport[7:0];
         drive_byte(b, i == len - 1);
      end
   endtask

   // drain all verdicts and let the pipeline empty before touching registers
   task automatic settle();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (verdicts_awaited != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CsrIdxWidth-1:0] idx,
                            input logic [CsrDataWidth-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
   endtask

   // load the whole filter; narrow registers get junk in their upper bits
   task automatic program_filter(input logic [31:0] src, input logic [31:0] smask,
                                 input logic [31:0] dst, input logic [31:0] dmask,
                                 input logic [31:0] ports, input logic [7:0] proto,
                                 input logic [1:0] action, input logic [15:0] mark);
      logic [31:0] noise;
      noise = $urandom;
      write_csr(RegSrcAddr, src);
      write_csr(RegSrcMask, smask);
      write_csr(RegDstAddr, dst);
      write_csr(RegDstMask, dmask);
      write_csr(RegPorts, ports);
      write_csr(RegProtocol, {noise[31:8], proto});
      write_csr(RegAction, {noise[31:2], action});
      write_csr(RegMarkIdx, {noise[31:16], mark});
      // unmapped index must be ignored
      write_csr(RegUnusedFirst + CsrIdxWidth'($urandom_range(0, 7)), $urandom);
      csr_write_enable <= 1'b0;
      f_src_addr = src;
      f_src_mask = smask;
      f_dst_addr = dst;
      f_dst_mask = dmask;
      f_ports    = ports;
      f_protocol = proto;
   endtask

   function automatic logic [31:0] random_mask();
      case ($urandom_range(0, 3))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         default: return 32'hFFFF_FFFF << $urandom_range(1, 31);
      endcase
   endfunction

   task automatic program_random_filter();
      logic [31:0] ports;
      logic [7:0]  proto;
      logic [15:0] mark;
      ports[31:16] = ($urandom_range(0, 2) == 0) ? 16'h0000 : 16'($urandom);
      ports[15:0]  = ($urandom_range(0, 2) == 0) ? 16'h0000 : 16'($urandom);
      case ($urandom_range(0, 3))
         0:       proto = 8'h00;
         1:       proto = ProtoTcp;
         2:       proto = ProtoUdp;
         default: proto = 8'($urandom);
      endcase
      case ($urandom_range(0, 3))
         0:       mark = 16'h0000;
         1:       mark = 16'hFFFF;
         default: mark = 16'($urandom);
      endcase
      program_filter($urandom, random_mask(), $urandom, random_mask(), ports, proto,
                     2'($urandom_range(0, 3)), mark);
   endtask

   // mostly well-formed ipv4 frames steered toward the filter, plus noise
   task automatic send_random_frame();
      int          kind;
      int          len;
      logic [15:0] etype;
      logic [7:0]  proto;
      logic [31:0] src;
      logic [31:0] dst;
      logic [15:0] sport;
      logic [15:0] dport;
      kind  = $urandom_range(0, 99);
      etype = EthertypeIpv4;
      src = ($urandom_range(0, 3) != 0) ? ((f_src_addr & f_src_mask) | ($urandom & ~f_src_mask))
                                         : $urandom;
      dst = ($urandom_range(0, 3) != 0) ? ((f_dst_addr & f_dst_mask) | ($urandom & ~f_dst_mask))
                                         : $urandom;
      sport = (f_ports[31:16] != 16'h0000 && $urandom_range(0, 3) != 0) ? f_ports[31:16]
                                                                        : 16'($urandom);
      dport = (f_ports[15:0] != 16'h0000 && $urandom_range(0, 3) != 0) ? f_ports[15:0]
                                                                       : 16'($urandom);
      case ($urandom_range(0, 3))
         0:       proto = ProtoTcp;
         1:       proto = ProtoUdp;
         2:       proto = (f_protocol != 8'h00) ? f_protocol : 8'($urandom);
         default: proto = 8'($urandom);
      endcase
      case ($urandom_range(0, 9))
         0:       len = $urandom_range(34, 41);
         1:       len = $urandom_range(41, 42);
         2:       len = $urandom_range(53, 54);
         8:       len = $urandom_range(55, 63);
         9:       len = $urandom_range(64, 90);
         default: len = $urandom_range(42, 64);
      endcase
      if (kind < 6) begin
         // runt
         len = $urandom_range(1, 13);
      end else if (kind < 14) begin
         // other ethertype
         len   = $urandom_range(14, 70);
         etype = 16'($urandom);
         if (etype == EthertypeIpv4) etype[0] = 1'b1;
      end else if (kind < 20) begin
         // ipv4 cut short inside the header
         len = $urandom_range(14, 33);
      end
      send_frame(len, etype, proto, src, dst, sport, dport, FillRandom);
   endtask

   initial begin
      int phase_frames;
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.data_byte = 8'h00;
      req_bus.last_byte = 1'b0;
      rsp_bus.ready     = 1'b0;
      csr_write_enable  = 1'b0;
      csr_index         = '0;
      csr_write_data    = '0;
      burst_left        = 0;
      gapless           = 1'b0;
      bytes_sent        = 0;
      f_src_addr        = '0;
      f_src_mask        = '0;
      f_dst_addr        = '0;
      f_dst_mask        = '0;
      f_ports           = '0;
      f_protocol        = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset filter: runts, other ethertype, short ipv4, missing ports, long frame
      send_frame(1, EthertypeIpv4, ProtoTcp, '0, '0, '0, '0, FillRandom);
      send_frame(13, EthertypeIpv4, ProtoTcp, '0, '0, '0, '0, FillRandom);
      send_frame(14, 16'h86DD, 8'h00, '0, '0, '0, '0, FillZero);
      send_frame(14, EthertypeIpv4, ProtoTcp, '0, '0, '0, '0, FillRandom);
      send_frame(33, EthertypeIpv4, ProtoUdp, $urandom, $urandom, '0, '0, FillRandom);
      send_frame(34, EthertypeIpv4, ProtoTcp, $urandom, $urandom, '0, '0, FillZero);
      send_frame(70, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
                 FillOnes);
      settle();

      // tcp filter that drops: exact source, destination /24, both ports
      program_filter(32'h0A00_0001, 32'hFFFF_FFFF, 32'hC0A8_0001, 32'hFFFF_FF00,
                     {16'd1234, 16'd80}, ProtoTcp, ActDrop, 16'h0000);
      send_frame(54, EthertypeIpv4, ProtoTcp, 32'h0A00_0001, 32'hC0A8_0077, 16'd1234, 16'd80,
                 FillRandom);
      send_frame(53, EthertypeIpv4, ProtoTcp, 32'h0A00_0001, 32'hC0A8_0077, 16'd1234, 16'd80,
                 FillRandom);
      send_frame(42, EthertypeIpv4, ProtoUdp, 32'h0A00_0001, 32'hC0A8_0001, 16'd1234, 16'd80,
                 FillRandom);
      settle();

      // udp destination port filter that marks
      program_filter(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                     {16'd0, 16'd53}, ProtoUdp, ActMark, 16'hFFFF);
      send_frame(42, EthertypeIpv4, ProtoUdp, $urandom, $urandom, 16'($urandom), 16'd53,
                 FillRandom);
      send_frame(41, EthertypeIpv4, ProtoUdp, $urandom, $urandom, 16'($urandom), 16'd53,
                 FillRandom);
      send_frame(64, EthertypeIpv4, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
                 FillOnes);
      settle();

      // all-ones filter with the pass action
      program_filter(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF, ProtoTcp, ActPass, 16'hFFFF);
      send_frame(80, EthertypeIpv4, ProtoTcp, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
                 FillOnes);
      settle();

      // random filters, several frames per setting
      phase_frames = 0;
      while (bytes_sent < ByteBudget) begin
         if (phase_frames == 0) begin
            settle();
            program_random_filter();
            phase_frames = $urandom_range(4, 10);
            gapless      = ($urandom_range(0, 3) == 0);
         end
         send_random_frame();
         phase_frames--;
      end

      // back to an all-zero filter with no action
      settle();
      program_filter(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 8'h00, ActNone, 16'h0000);
      send_frame(60, EthertypeIpv4, ProtoTcp, $urandom, $urandom, 16'($urandom), 16'($urandom),
                 FillRandom);
      settle();
      repeat (8) @(posedge clock);

      if (mismatch_count == 0 && verdicts_awaited == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+src
src/iftc_pkg.sv
src/iftc_if.sv
src/iftc_parser.sv
src/iftc_classifier.sv
src/ipv4_five_tuple_classifier_unit.sv
bench/iftc_verdict_checker.sv
bench/ipv4_five_tuple_classifier_unit_test.sv
